@@ design/occupancy_grid_inflation_defines.svh @@
// ---------------------------------------------------------------------------
// occupancy grid inflation assertion macros
// shared concurrent assertion forms, sampled on clk_i, off during reset
// ---------------------------------------------------------------------------
`ifndef OCCUPANCY_GRID_INFLATION_DEFINES_SVH
`define OCCUPANCY_GRID_INFLATION_DEFINES_SVH

// same-cycle implication
`define OGI_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ogi assertion failed");

// next-cycle implication
`define OGI_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ogi assertion failed");

`endif

@@ design/ogi_pkg.sv @@
// ---------------------------------------------------------------------------
// ogi_pkg
// constants, types and cost table of the occupancy grid inflation block
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package ogi_pkg;

  localparam int unsigned GRID_SIDE       = 512;
  localparam int unsigned INFLATION_CELLS = 4;

  localparam int unsigned COORD_W = 9;
  localparam int unsigned COST_W  = 7;
  localparam int unsigned DSQ_W   = 6;
  localparam int unsigned ROW_W   = $clog2(GRID_SIDE);
  localparam int unsigned POS_W   = ((ROW_W > COORD_W) ? ROW_W : COORD_W) + 2;
  localparam int unsigned WIN     = 2 * INFLATION_CELLS + 1;
  localparam int unsigned LIMIT   = INFLATION_CELLS * INFLATION_CELLS;
  localparam int unsigned QSQ_W   = $clog2(2 * LIMIT + 1);
  localparam int unsigned DR_W    = $clog2(INFLATION_CELLS + 1);
  localparam int unsigned CNT_W   = $clog2(WIN);

  localparam logic [COST_W-1:0] FULL_COST = COST_W'(100);

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_MARK  = 2'd1,
    OP_FREE  = 2'd2,
    OP_QUERY = 2'd3
  } op_e;

  typedef logic [GRID_SIDE-1:0] row_word_t;

  typedef struct packed {
    logic [COST_W-1:0] cost;
    logic              occupied;
    logic              inflated;
    logic [DSQ_W-1:0]  nearest_dist_sq;
  } result_t;

  typedef struct packed {
    logic            clear;
    logic            step;
    logic            row_ok;
    logic [DR_W-1:0] dr;
  } win_ctrl_t;

  typedef logic [2**DSQ_W-1:0][COST_W-1:0] cost_lut_t;

  // cost = 100 - largest k with (k*R)^2 <= 10000*d^2
  function automatic cost_lut_t build_cost_lut();
    cost_lut_t   lut;
    int unsigned lim;
    int unsigned k;
    int unsigned kr;
    lut = '0;
    for (int unsigned d2 = 0; d2 < 2**DSQ_W; d2++) begin
      lim = 10000 * d2;
      k   = 100;
      for (int unsigned s = 0; s < 100; s++) begin
        kr = k * INFLATION_CELLS;
        if (k > 0 && kr * kr > lim) begin
          k = k - 1;
        end
      end
      lut[d2] = COST_W'(100 - k);
    end
    return lut;
  endfunction

  localparam cost_lut_t COST_LUT = build_cost_lut();

endpackage

@@ design/ogi_cmd_if.sv @@
// ---------------------------------------------------------------------------
// ogi_cmd_if
// command channel: valid/ready with operation and cell address
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface ogi_cmd_if;
  import ogi_pkg::*;

  logic               valid;
  logic               ready;
  op_e                operation;
  logic [COORD_W-1:0] row;
  logic [COORD_W-1:0] col;

  modport source (output valid, output operation, output row, output col, input ready);
  modport sink   (input valid, input operation, input row, input col, output ready);
endinterface

@@ design/ogi_res_if.sv @@
// ---------------------------------------------------------------------------
// ogi_res_if
// result channel: valid/ready with cost and distance fields
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface ogi_res_if;
  import ogi_pkg::*;

  logic              valid;
  logic              ready;
  logic [COST_W-1:0] cost;
  logic              occupied;
  logic              inflated;
  logic [DSQ_W-1:0]  nearest_dist_sq;

  modport source (output valid, output cost, output occupied, output inflated,
                  output nearest_dist_sq, input ready);
  modport sink   (input valid, input cost, input occupied, input inflated,
                  input nearest_dist_sq, output ready);
endinterface

@@ design/ogi_row_ram.sv @@
// ---------------------------------------------------------------------------
// ogi_row_ram
// generic single-write, single-read memory with registered read data
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module ogi_row_ram #(
  parameter int unsigned DEPTH = 512,
  parameter int unsigned WIDTH = 512,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/ogi_win.sv @@
// ---------------------------------------------------------------------------
// ogi_win
// shared row evaluator: nearest obstacle in one grid row of the window,
// folded into a running minimum of the squared distance
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module ogi_win (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  ogi_pkg::win_ctrl_t          ctrl_i,
  input  ogi_pkg::row_word_t          word_i,
  input  logic [ogi_pkg::COORD_W-1:0] col_i,
  output logic [ogi_pkg::DSQ_W-1:0]   best_o,
  output logic                        center_o
);
  import ogi_pkg::*;

  logic [QSQ_W-1:0] dr_ext;
  logic [QSQ_W-1:0] drsq;
  logic [POS_W-1:0] cpos;
  logic [QSQ_W-1:0] q;
  logic [QSQ_W-1:0] cand;
  logic             hit;
  logic [DSQ_W-1:0] best_q;
  logic             center_q;

  // nearest hit within this row
  always_comb begin
    dr_ext = QSQ_W'(ctrl_i.dr);
    drsq   = dr_ext * dr_ext;
    cand   = '0;
    cpos   = '0;
    q      = '0;
    hit    = 1'b0;
    for (int unsigned j = 0; j < WIN; j++) begin
      cpos = POS_W'(col_i) + POS_W'(j) - POS_W'(INFLATION_CELLS);
      q    = drsq + QSQ_W'((j - INFLATION_CELLS) * (j - INFLATION_CELLS));
      hit  = !cpos[POS_W-1] && (cpos < POS_W'(GRID_SIDE)) && word_i[cpos[ROW_W-1:0]]
             && (q != '0) && (q <= QSQ_W'(LIMIT));
      if (hit && (cand == '0 || q < cand)) begin
        cand = q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_q   <= '0;
      center_q <= 1'b0;
    end else if (ctrl_i.clear) begin
      best_q   <= '0;
      center_q <= 1'b0;
    end else if (ctrl_i.step && ctrl_i.row_ok) begin
      if (cand != '0 && (best_q == '0 || DSQ_W'(cand) < best_q)) begin
        best_q <= DSQ_W'(cand);
      end
      if (ctrl_i.dr == '0) begin
        center_q <= word_i[ROW_W'(col_i)];
      end
    end
  end

  assign best_o   = best_q;
  assign center_o = center_q;

endmodule

@@ design/occupancy_grid_inflation.sv @@
// ---------------------------------------------------------------------------
// occupancy_grid_inflation
// obstacle grid with inflated-cost queries over a row-organized memory
// ---------------------------------------------------------------------------
// usage:
//   cmd_i carries one command item: clear grid, mark obstacle, mark free or
//   query; res_o returns exactly one result item per command, in order.
//   cmd_i.ready is high only while the sequencer is idle; one command is
//   worked on at a time.
//   query: 9 window row steps (one grid row word per cycle through the shared row
//   evaluator), then a drain state and a result state.
//   mark obstacle / mark free: read-modify-write of one row.
//   clear grid: one row per cycle over all 512 rows.
//   commands or queries addressed outside the grid skip straight to result.
//   after reset the grid memory is swept to zero, all 512 rows, before the
//   first command is taken.
//   the result sits in an output register; a new command may be taken while
//   it waits, but the next result is held back until res_o.ready takes the
//   previous one.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "occupancy_grid_inflation_defines.svh"

module occupancy_grid_inflation (
  input  logic           clk_i,
  input  logic           rst_ni,
  ogi_cmd_if.sink        cmd_i,
  ogi_res_if.source      res_o
);
  import ogi_pkg::*;

  typedef enum logic [7:0] {
    S_INIT    = 8'b0000_0001,
    S_IDLE    = 8'b0000_0010,
    S_CLEAR   = 8'b0000_0100,
    S_MARK_RD = 8'b0000_1000,
    S_MARK_WR = 8'b0001_0000,
    S_QUERY   = 8'b0010_0000,
    S_DRAIN   = 8'b0100_0000,
    S_DONE    = 8'b1000_0000
  } state_e;

  state_e             state_q, state_d;
  logic [ROW_W-1:0]   cnt_q, cnt_d;
  logic [CNT_W-1:0]   qcnt_q, qcnt_d;
  op_e                op_q;
  logic [COORD_W-1:0] row_q;
  logic [COORD_W-1:0] col_q;
  logic               inside_q;
  win_ctrl_t          ctrl_q, ctrl_d;
  logic               res_valid_q, res_valid_d;
  result_t            res_q, res_d;
  logic               load_res;

  logic               accept;
  logic               inside_in;
  logic [POS_W-1:0]   rpos;
  logic               row_ok;
  logic [CNT_W-1:0]   dr_full;

  logic               we;
  logic [ROW_W-1:0]   waddr;
  row_word_t          wdata;
  logic               re;
  logic [ROW_W-1:0]   raddr;
  row_word_t          rdata;
  row_word_t          mod_word;
  logic [DSQ_W-1:0]   best;
  logic               center;

  assign cmd_i.ready = (state_q == S_IDLE);
  assign accept      = cmd_i.valid && cmd_i.ready;
  assign inside_in   = (POS_W'(cmd_i.row) < POS_W'(GRID_SIDE))
                       && (POS_W'(cmd_i.col) < POS_W'(GRID_SIDE));

  // window row address and distance for the current step
  assign rpos    = POS_W'(row_q) + POS_W'(qcnt_q) - POS_W'(INFLATION_CELLS);
  assign row_ok  = !rpos[POS_W-1] && (rpos < POS_W'(GRID_SIDE));
  assign dr_full = (qcnt_q >= CNT_W'(INFLATION_CELLS))
                   ? (qcnt_q - CNT_W'(INFLATION_CELLS))
                   : (CNT_W'(INFLATION_CELLS) - qcnt_q);

  always_comb begin
    mod_word                 = rdata;
    mod_word[ROW_W'(col_q)]  = (op_q == OP_MARK);
  end

  always_comb begin
    we    = (state_q == S_INIT) || (state_q == S_CLEAR) || (state_q == S_MARK_WR);
    waddr = (state_q == S_MARK_WR) ? ROW_W'(row_q) : cnt_q;
    wdata = (state_q == S_MARK_WR) ? mod_word : '0;
    re    = (state_q == S_MARK_RD) || ((state_q == S_QUERY) && row_ok);
    raddr = (state_q == S_MARK_RD) ? ROW_W'(row_q) : rpos[ROW_W-1:0];
  end

  ogi_row_ram #(
    .DEPTH (GRID_SIDE),
    .WIDTH (GRID_SIDE)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // step control lines up with the registered read data
  always_comb begin
    ctrl_d.clear  = accept;
    ctrl_d.step   = (state_q == S_QUERY);
    ctrl_d.row_ok = row_ok;
    ctrl_d.dr     = DR_W'(dr_full);
  end

  ogi_win u_win (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (ctrl_q),
    .word_i   (rdata),
    .col_i    (col_q),
    .best_o   (best),
    .center_o (center)
  );

  always_comb begin
    res_d = '0;
    if (op_q == OP_QUERY && inside_q) begin
      if (center) begin
        res_d.cost     = FULL_COST;
        res_d.occupied = 1'b1;
      end else if (best != '0) begin
        res_d.cost            = COST_LUT[best];
        res_d.inflated        = 1'b1;
        res_d.nearest_dist_sq = best;
      end
    end
  end

  assign load_res = (state_q == S_DONE) && (!res_valid_q || res_o.ready);

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    qcnt_d      = qcnt_q;
    res_valid_d = res_valid_q;
    if (res_o.ready) begin
      res_valid_d = 1'b0;
    end
    unique case (state_q)
      S_INIT: begin
        cnt_d = cnt_q + ROW_W'(1);
        if (cnt_q == ROW_W'(GRID_SIDE - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        cnt_d  = '0;
        qcnt_d = '0;
        if (accept) begin
          unique case (cmd_i.operation)
            OP_CLEAR:         state_d = S_CLEAR;
            OP_MARK, OP_FREE: state_d = inside_in ? S_MARK_RD : S_DONE;
            OP_QUERY:         state_d = inside_in ? S_QUERY : S_DONE;
            default:          state_d = S_DONE;
          endcase
        end
      end
      S_CLEAR: begin
        cnt_d = cnt_q + ROW_W'(1);
        if (cnt_q == ROW_W'(GRID_SIDE - 1)) begin
          state_d = S_DONE;
        end
      end
      S_MARK_RD: state_d = S_MARK_WR;
      S_MARK_WR: state_d = S_DONE;
      S_QUERY: begin
        qcnt_d = qcnt_q + CNT_W'(1);
        if (qcnt_q == CNT_W'(WIN - 1)) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: state_d = S_DONE;
      S_DONE: begin
        if (load_res) begin
          res_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      cnt_q       <= '0;
      qcnt_q      <= '0;
      ctrl_q      <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      qcnt_q      <= qcnt_d;
      ctrl_q      <= ctrl_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q     <= cmd_i.operation;
      row_q    <= cmd_i.row;
      col_q    <= cmd_i.col;
      inside_q <= inside_in;
    end
    if (load_res) begin
      res_q <= res_d;
    end
  end

  assign res_o.valid           = res_valid_q;
  assign res_o.cost            = res_q.cost;
  assign res_o.occupied        = res_q.occupied;
  assign res_o.inflated        = res_q.inflated;
  assign res_o.nearest_dist_sq = res_q.nearest_dist_sq;

  `OGI_ASSERT_NXT(a_busy_after_accept, cmd_i.valid && cmd_i.ready, !cmd_i.ready)
  `OGI_ASSERT_IMP(a_occupied_full_cost, res_o.valid && res_o.occupied,
                  res_o.cost == FULL_COST && !res_o.inflated && res_o.nearest_dist_sq == '0)
  `OGI_ASSERT_IMP(a_inflated_in_radius, res_o.valid && res_o.inflated,
                  res_o.nearest_dist_sq != '0 && res_o.nearest_dist_sq <= DSQ_W'(LIMIT))
  `OGI_ASSERT_IMP(a_free_zero_cost, res_o.valid && !res_o.occupied && !res_o.inflated,
                  res_o.cost == '0 && res_o.nearest_dist_sq == '0)

endmodule
